// ===== rtl/mjsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mjsd_pkg
// Shared types and constants of the mjpeg stream deframer.
// ----------------------------------------------------------------------------
package mjsd_pkg;

  // byte offset of the first status digit in the response
  localparam logic [12:0] STATUS_OFFSET = 13'd9;

  localparam logic [12:0] HDR_SAT    = 13'h1fff;
  localparam logic [9:0]  STATUS_SAT = 10'h3ff;
  localparam logic [16:0] LEN_SAT    = 17'h1ffff;
  localparam logic [9:0]  STATUS_OK  = 10'd200;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_LEN  = 2'd0;
  localparam logic [1:0] CFG_MAX_LEN  = 2'd1;
  localparam logic [1:0] CFG_HDR_LIM  = 2'd2;

  localparam logic [15:0] MIN_LEN_RST = 16'd100;
  localparam logic [16:0] MAX_LEN_RST = 17'd51200;
  localparam logic [12:0] HDR_LIM_RST = 13'd1024;

  // verdict codes
  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_TOO_SMALL = 3'd1;
  localparam logic [2:0] VERDICT_TOO_LARGE = 3'd2;
  localparam logic [2:0] VERDICT_BAD_STAT  = 3'd3;
  localparam logic [2:0] VERDICT_OVERRUN   = 3'd4;

  // stream bytes of interest
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_FF  = 8'hff;
  localparam logic [7:0] BYTE_SOI = 8'hd8;
  localparam logic [7:0] BYTE_EOI = 8'hd9;
  localparam logic [7:0] BYTE_D0  = 8'h30;
  localparam logic [7:0] BYTE_D9  = 8'h39;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_HUNT   = 4'b0010,
    PH_FRAME  = 4'b0100,
    PH_HALT   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [15:0] min_len;
    logic [16:0] max_len;
    logic [12:0] hdr_lim;
  } cfg_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_start;
    logic       frame_end;
    logic [2:0] verdict;
  } res_t;

  // results caused by one stream byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } res_pair_t;

endpackage

// ===== rtl/mjsd_core.sv =====
// ----------------------------------------------------------------------------
// mjsd_core
// Header parser and SOI/EOI frame cutter; one stream byte per accept.
// ----------------------------------------------------------------------------
module mjsd_core import mjsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_vld,
  input  logic [7:0] byte_in,
  input  cfg_t       cfg,
  output res_pair_t  results
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  term_r, term_nxt;
  logic [12:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [9:0]  status_r, status_nxt;
  logic        status_done_r, status_done_nxt;
  logic        prev_ff_r, prev_ff_nxt;
  logic [16:0] flen_r, flen_nxt;

  logic        is_digit;
  logic [13:0] st_mul;
  logic        hdr_done;

  assign is_digit = (byte_in >= BYTE_D0) && (byte_in <= BYTE_D9);
  // status * 10 + digit
  assign st_mul = ({4'd0, status_r} << 3) + ({4'd0, status_r} << 1)
                  + {10'd0, byte_in[3:0]};

  always_comb begin
    phase_nxt       = phase_r;
    term_nxt        = term_r;
    hdr_cnt_nxt     = hdr_cnt_r;
    status_nxt      = status_r;
    status_done_nxt = status_done_r;
    prev_ff_nxt     = prev_ff_r;
    flen_nxt        = flen_r;
    hdr_done        = 1'b0;
    results         = '0;

    case (phase_r)
      PH_HEADER: begin
        if (!status_done_r && (hdr_cnt_r >= STATUS_OFFSET)) begin
          if (is_digit) begin
            status_nxt = (st_mul > {4'd0, STATUS_SAT}) ? STATUS_SAT : st_mul[9:0];
          end else begin
            status_done_nxt = 1'b1;
          end
        end
        if (hdr_cnt_r != HDR_SAT) hdr_cnt_nxt = hdr_cnt_r + 13'd1;

        // cr lf cr lf matcher
        if (byte_in == BYTE_CR) begin
          term_nxt = (term_r == 2'd2) ? 2'd3 : 2'd1;
        end else if (byte_in == BYTE_LF) begin
          if (term_r == 2'd1) term_nxt = 2'd2;
          else begin
            hdr_done = (term_r == 2'd3);
            term_nxt = 2'd0;
          end
        end else begin
          term_nxt = 2'd0;
        end

        if (hdr_done) begin
          if (status_nxt != STATUS_OK) begin
            phase_nxt            = PH_HALT;
            results.cnt          = 2'd1;
            results.res0.frame_end = 1'b1;
            results.res0.verdict = VERDICT_BAD_STAT;
          end else begin
            phase_nxt   = PH_HUNT;
            prev_ff_nxt = 1'b0;
          end
        end else if (hdr_cnt_nxt >= cfg.hdr_lim) begin
          phase_nxt            = PH_HALT;
          results.cnt          = 2'd1;
          results.res0.frame_end = 1'b1;
          results.res0.verdict = VERDICT_OVERRUN;
        end
      end
      PH_HUNT: begin
        if (prev_ff_r && (byte_in == BYTE_SOI)) begin
          results.cnt              = 2'd2;
          results.res0.frame_byte  = BYTE_FF;
          results.res0.frame_start = 1'b1;
          results.res1.frame_byte  = BYTE_SOI;
          flen_nxt    = 17'd2;
          prev_ff_nxt = 1'b0;
          phase_nxt   = PH_FRAME;
        end else begin
          prev_ff_nxt = (byte_in == BYTE_FF);
        end
      end
      PH_FRAME: begin
        if (flen_r != LEN_SAT) flen_nxt = flen_r + 17'd1;
        results.cnt             = 2'd1;
        results.res0.frame_byte = byte_in;
        if (prev_ff_r && (byte_in == BYTE_EOI)) begin
          results.res0.frame_end = 1'b1;
          if (flen_nxt > cfg.max_len) results.res0.verdict = VERDICT_TOO_LARGE;
          else if (flen_nxt < {1'b0, cfg.min_len})
            results.res0.verdict = VERDICT_TOO_SMALL;
          else results.res0.verdict = VERDICT_OK;
          prev_ff_nxt = 1'b0;
          phase_nxt   = PH_HUNT;
        end else begin
          prev_ff_nxt = (byte_in == BYTE_FF);
        end
      end
      PH_HALT: begin
        // bytes ignored until reset
      end
      default: begin
        phase_nxt = PH_HALT;
      end
    endcase

    if (!byte_vld) results.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      term_r        <= 2'd0;
      hdr_cnt_r     <= 13'd0;
      status_r      <= 10'd0;
      status_done_r <= 1'b0;
      prev_ff_r     <= 1'b0;
      flen_r        <= 17'd0;
    end else if (byte_vld) begin
      phase_r       <= phase_nxt;
      term_r        <= term_nxt;
      hdr_cnt_r     <= hdr_cnt_nxt;
      status_r      <= status_nxt;
      status_done_r <= status_done_nxt;
      prev_ff_r     <= prev_ff_nxt;
      flen_r        <= flen_nxt;
    end
  end

endmodule

// ===== rtl/mjsd_outq.sv =====
// ----------------------------------------------------------------------------
// mjsd_outq
// Four-entry result queue; takes up to two results per cycle, emits one when pop_rdy is high.
// ----------------------------------------------------------------------------
module mjsd_outq import mjsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  res_pair_t push,
  output logic      room,
  output logic      pop_vld,
  input  logic      pop_rdy,
  output res_t      pop_data
);

  res_t       mem [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign room     = (cnt_r <= 3'd2);
  assign pop_vld  = (cnt_r != 3'd0);
  assign pop      = pop_vld && pop_rdy;
  assign pop_data = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + push.cnt;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push.cnt} - {2'd0, pop};
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wp_r] <= push.res0;
    if (push.cnt == 2'd2) mem[wp_r + 2'd1] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/mjpeg_stream_deframer.sv =====
// ----------------------------------------------------------------------------
// mjpeg_stream_deframer
// Cuts JPEG frames (SOI through EOI) out of an MJPEG-over-HTTP byte stream.
// ----------------------------------------------------------------------------
// One input word is one byte of the HTTP response. The block takes one byte
// per cycle: the header parser and frame cutter update their state in the
// cycle the byte is accepted and drop the resulting words into a four-entry
// output queue. A byte gives at most one output word, except the D8 of an
// SOI which gives two (FF then D8), so in_tready falls only when the queue
// holds more than two words; with out_tready high the sustained rate is one
// byte per cycle. A bad status (not 200) or a header that reaches
// header_limit without CR LF CR LF gives a single error word and halts the
// block until reset. There is no clearing pass after reset. Configuration
// should be written while the stream is idle.
// ----------------------------------------------------------------------------
module mjpeg_stream_deframer import mjsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [16:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast,  // frame_end
  output logic [3:0]  out_tuser   // [0] frame_start, [3:1] verdict
);

  cfg_t      cfg_r;
  res_pair_t results;
  res_t      head;
  logic      accept;

  assign accept = in_tvalid && in_tready;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_len <= MIN_LEN_RST;
      cfg_r.max_len <= MAX_LEN_RST;
      cfg_r.hdr_lim <= HDR_LIM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_MIN_LEN: cfg_r.min_len <= cfg_wdata[15:0];
        CFG_MAX_LEN: cfg_r.max_len <= cfg_wdata;
        CFG_HDR_LIM: cfg_r.hdr_lim <= cfg_wdata[12:0];
        default: begin
        end
      endcase
    end
  end

  // parser and frame cutter
  mjsd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (accept),
    .byte_in  (in_tdata),
    .cfg      (cfg_r),
    .results  (results)
  );

  // output queue parts the two handshakes
  mjsd_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (results),
    .room     (in_tready),
    .pop_vld  (out_tvalid),
    .pop_rdy  (out_tready),
    .pop_data (head)
  );

  assign out_tdata = head.frame_byte;
  assign out_tlast = head.frame_end;
  assign out_tuser = {head.verdict, head.frame_start};

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mjpeg stream deframer.
// ----------------------------------------------------------------------------
// Sends one HTTP response into the block. The header has a 200 status and
// ends exactly on the header limit. The body follows with a directed run of
// markers and then random frames, stray markers, noise and frames cut short,
// under several length limits. Each output word is checked against a bit-accurate
// frame cutter in the bench, or a word typed in the directed run. Both handshakes
// idle at random; the sink holds off once for a long stretch to back up the block.
// ----------------------------------------------------------------------------
module tb;
  import mjsd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int ITEMS_TARGET = 750;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_WORDS = 90;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [16:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] stream_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] frame_byte
  logic        out_tlast;  // frame_end
  logic [3:0]  out_tuser;  // [0] frame_start, [3:1] verdict

  mjpeg_stream_deframer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // directed body rows: typed_n < 0 means the frame cutter supplies the words
  typedef struct {
    logic [7:0] data;
    int         typed_n;
    res_t       w0;
    res_t       w1;
  } body_row_t;

  // runs with min 5, max 6 right after the header
  body_row_t body_rows [22] = '{
    '{8'h00, -1, '0, '0},                                  // zero byte, hunting
    '{BYTE_EOI, -1, '0, '0},                               // lone d9 is ignored
    '{8'h7f, -1, '0, '0},
    '{BYTE_FF, -1, '0, '0},
    '{BYTE_SOI, 2, '{BYTE_FF, 1'b1, 1'b0, VERDICT_OK},
                   '{BYTE_SOI, 1'b0, 1'b0, VERDICT_OK}},
    '{BYTE_FF, -1, '0, '0},
    '{BYTE_EOI, 1, '{BYTE_EOI, 1'b0, 1'b1, VERDICT_TOO_SMALL}, '0}, // 4-byte frame
    '{8'h80, -1, '0, '0},
    '{BYTE_FF, -1, '0, '0},                                // run of ff before soi
    '{BYTE_FF, -1, '0, '0},
    '{BYTE_FF, -1, '0, '0},
    '{BYTE_SOI, 2, '{BYTE_FF, 1'b1, 1'b0, VERDICT_OK},
                   '{BYTE_SOI, 1'b0, 1'b0, VERDICT_OK}},
    '{BYTE_EOI, 1, '{BYTE_EOI, 1'b0, 1'b0, VERDICT_OK}, '0}, // soi d8 never pairs
    '{BYTE_FF, -1, '0, '0},
    '{BYTE_SOI, 1, '{BYTE_SOI, 1'b0, 1'b0, VERDICT_OK}, '0}, // d8 inside is data
    '{BYTE_FF, -1, '0, '0},
    '{BYTE_EOI, 1, '{BYTE_EOI, 1'b0, 1'b1, VERDICT_TOO_LARGE}, '0}, // 7 bytes
    '{BYTE_FF, -1, '0, '0},
    '{BYTE_SOI, 2, '{BYTE_FF, 1'b1, 1'b0, VERDICT_OK},
                   '{BYTE_SOI, 1'b0, 1'b0, VERDICT_OK}},
    '{8'h00, -1, '0, '0},
    '{BYTE_FF, -1, '0, '0},
    '{BYTE_EOI, 1, '{BYTE_EOI, 1'b0, 1'b1, VERDICT_OK}, '0}  // 5 bytes, in range
  };

  // frame cutter state and its copy of the registers
  cfg_t        shadow_cfg;
  phase_t      ph;
  int          crlf_seen;
  logic [12:0] hdr_bytes;
  logic [9:0]  status_num;
  logic        status_closed;
  logic        last_ff;
  logic [16:0] frame_bytes;

  res_t words_due [$];     // expected output words, oldest first
  int   stream_words;      // words taken by the block
  int   frame_words;       // words checked on the output
  int   frame_ends;
  int   off_length;        // frames that closed with a length verdict
  int   mismatches;
  int   cycles;
  int   src_calm;
  int   sink_calm;
  bit   hold_req;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // idle length: mostly none, some short, a few long, with calm stretches
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) calm = $urandom_range(20, 60);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // header parse and frame cut for one stream byte; returns the word count
  function automatic int cut_frames(input logic [7:0] b, output res_t r0, output res_t r1);
    logic       term;
    int         v;
    logic [2:0] vd;
    r0 = '0;
    r1 = '0;
    term = 1'b0;
    case (ph)
      PH_HEADER: begin
        // status digits start at a fixed offset, first non-digit closes it
        if (!status_closed && hdr_bytes >= STATUS_OFFSET) begin
          if (b >= BYTE_D0 && b <= BYTE_D9) begin
            v = int'(status_num) * 10 + int'(b - BYTE_D0);
            status_num = (v > int'(STATUS_SAT)) ? STATUS_SAT : 10'(v);
          end else begin
            status_closed = 1'b1;
          end
        end
        if (hdr_bytes != HDR_SAT) hdr_bytes = hdr_bytes + 13'd1;
        // cr lf cr lf tracker
        if (b == BYTE_CR) begin
          crlf_seen = (crlf_seen == 2) ? 3 : 1;
        end else if (b == BYTE_LF) begin
          if (crlf_seen == 1) begin
            crlf_seen = 2;
          end else begin
            term = (crlf_seen == 3);
            crlf_seen = 0;
          end
        end else begin
          crlf_seen = 0;
        end
        // terminator wins over the limit on the same byte
        if (term) begin
          if (status_num != STATUS_OK) begin
            ph = PH_HALT;
            r0 = '{8'h00, 1'b0, 1'b1, VERDICT_BAD_STAT};
            return 1;
          end
          ph = PH_HUNT;
          last_ff = 1'b0;
          return 0;
        end
        if (hdr_bytes >= shadow_cfg.hdr_lim) begin
          ph = PH_HALT;
          r0 = '{8'h00, 1'b0, 1'b1, VERDICT_OVERRUN};
          return 1;
        end
        return 0;
      end
      PH_HUNT: begin
        if (last_ff && b == BYTE_SOI) begin
          r0 = '{BYTE_FF, 1'b1, 1'b0, VERDICT_OK};
          r1 = '{BYTE_SOI, 1'b0, 1'b0, VERDICT_OK};
          frame_bytes = 17'd2;
          last_ff = 1'b0;
          ph = PH_FRAME;
          return 2;
        end
        last_ff = (b == BYTE_FF);
        return 0;
      end
      PH_FRAME: begin
        if (frame_bytes != LEN_SAT) frame_bytes = frame_bytes + 17'd1;
        if (last_ff && b == BYTE_EOI) begin
          // too large is checked first
          vd = VERDICT_OK;
          if (frame_bytes > shadow_cfg.max_len) vd = VERDICT_TOO_LARGE;
          else if (frame_bytes < {1'b0, shadow_cfg.min_len}) vd = VERDICT_TOO_SMALL;
          r0 = '{b, 1'b0, 1'b1, vd};
          last_ff = 1'b0;
          ph = PH_HUNT;
          return 1;
        end
        last_ff = (b == BYTE_FF);
        r0 = '{b, 1'b0, 1'b0, VERDICT_OK};
        return 1;
      end
      default: return 0;  // halted
    endcase
  endfunction

  // offer one stream word; the cutter runs at the accepting edge
  task automatic put_byte(input logic [7:0] b, input int typed_n, input res_t t0,
                          input res_t t1);
    int   gap;
    int   n;
    res_t p0;
    res_t p1;
    gap = idle_len(src_calm);
    if (gap > 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    n = cut_frames(b, p0, p1);
    if (typed_n >= 0) begin
      n = typed_n;
      p0 = t0;
      p1 = t1;
    end
    if (n > 0) words_due.push_back(p0);
    if (n > 1) words_due.push_back(p1);
    stream_words++;
  endtask

  task automatic send(input logic [7:0] b);
    put_byte(b, -1, '0, '0);
  endtask

  // register write while the stream is quiet
  task automatic set_reg(input logic [1:0] idx, input logic [16:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk) cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_LEN: shadow_cfg.min_len = val[15:0];
      CFG_MAX_LEN: shadow_cfg.max_len = val;
      CFG_HDR_LIM: shadow_cfg.hdr_lim = val[12:0];
      default: ;
    endcase
  endtask

  // drop valid, drain every expected word, then let the pipe go quiet
  task automatic settle();
    @(negedge clk) in_tvalid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // markers show up often so that frames open and close inside random data
  function automatic logic [7:0] stray_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return BYTE_FF;
    if (r == 2) return BYTE_SOI;
    if (r == 3) return BYTE_EOI;
    return 8'($urandom_range(0, 255));
  endfunction

  // noise, soi behind a run of ff, payload, and eoi unless cut short
  task automatic send_frame(input int payload_cnt, input bit close);
    repeat ($urandom_range(0, 4)) send(stray_byte());
    repeat ($urandom_range(1, 3)) send(BYTE_FF);
    send(BYTE_SOI);
    repeat (payload_cnt) send(stray_byte());
    if (close) begin
      send(BYTE_FF);
      send(BYTE_EOI);
    end
  endtask

  // sink: random stalls, one long hold-off on request
  initial begin : sink
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = idle_len(sink_calm);
      end
      if (stall > 0) begin
        @(negedge clk) out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_tready <= 1'b1;
    end
  end

  // output check against the oldest expected word
  always @(posedge clk) begin : check_words
    res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      frame_words++;
      if (words_due.size() == 0) begin
        $error("unexpected word: frame_byte %h tlast %b tuser %h", out_tdata, out_tlast,
               out_tuser);
        mismatches++;
      end else begin
        e = words_due.pop_front();
        if (out_tdata !== e.frame_byte) begin
          $error("frame_byte: expected %h, got %h", e.frame_byte, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== e.frame_start) begin
          $error("frame_start: expected %b, got %b", e.frame_start, out_tuser[0]);
          mismatches++;
        end
        if (out_tlast !== e.frame_end) begin
          $error("frame_end: expected %b, got %b", e.frame_end, out_tlast);
          mismatches++;
        end
        if (out_tuser[3:1] !== e.verdict) begin
          $error("verdict: expected %0d, got %0d", e.verdict, out_tuser[3:1]);
          mismatches++;
        end
        if (e.frame_end) begin
          frame_ends++;
          if (e.verdict != VERDICT_OK) off_length++;
        end
      end
    end
  end

  // stimulus
  initial begin : stim
    logic [7:0] hdr_q [$];
    string      s;
    int         i;
    int         phase_no;
    int         start;
    int         r;
    int         len;
    int         mn;
    int         mx;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'h00;
    cfg_we = 1'b0;
    cfg_idx = CFG_MIN_LEN;
    cfg_wdata = '0;
    shadow_cfg = '{MIN_LEN_RST, MAX_LEN_RST, HDR_LIM_RST};
    ph = PH_HEADER;
    crlf_seen = 0;
    hdr_bytes = '0;
    status_num = '0;
    status_closed = 1'b0;
    last_ff = 1'b0;
    frame_bytes = '0;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // register extremes while still in the header phase
    set_reg(CFG_HDR_LIM, 17'd4096);
    set_reg(CFG_MIN_LEN, 17'd65535);
    set_reg(CFG_MAX_LEN, 17'd131071);
    set_reg(CFG_HDR_LIM, 17'd16);

    // status line plus a few padding lines of printable text
    s = "HTTP/1.1 200 OK\r\n";
    for (i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
    repeat ($urandom_range(0, 3)) begin
      s = "X-Pad: ";
      for (i = 0; i < s.len(); i++) hdr_q.push_back(s[i]);
      repeat ($urandom_range(1, 20)) hdr_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
      hdr_q.push_back(BYTE_CR);
      hdr_q.push_back(BYTE_LF);
    end
    hdr_q.push_back(BYTE_CR);
    hdr_q.push_back(BYTE_LF);

    // terminator lands on the very byte that reaches the limit
    set_reg(CFG_HDR_LIM, 17'(hdr_q.size()));
    foreach (hdr_q[k]) send(hdr_q[k]);
    settle();

    // directed body
    set_reg(CFG_MIN_LEN, 17'd5);
    set_reg(CFG_MAX_LEN, 17'd6);
    foreach (body_rows[k])
      put_byte(body_rows[k].data, body_rows[k].typed_n, body_rows[k].w0, body_rows[k].w1);

    // random body, one length setting per phase
    phase_no = 0;
    while (stream_words < ITEMS_TARGET) begin
      settle();
      case (phase_no)
        0: begin mn = 0;     mx = 131071; end
        1: begin mn = 65535; mx = 131071; end
        2: begin mn = 0;     mx = 1;      end
        3: begin mn = 50;    mx = 10;     end  // min above max
        4: begin mn = int'(MIN_LEN_RST); mx = int'(MAX_LEN_RST); end
        default: begin
          mn = $urandom_range(0, 45);
          mx = $urandom_range(1, 60);
        end
      endcase
      set_reg(CFG_MIN_LEN, 17'(mn));
      set_reg(CFG_MAX_LEN, 17'(mx));
      // sink stalls for a long stretch while frames keep coming
      if (phase_no == 0) hold_req = 1'b1;
      start = stream_words;
      while (stream_words - start < PHASE_WORDS) begin
        r = $urandom_range(0, 9);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 300) : $urandom_range(0, 40);
        if (r == 0) repeat ($urandom_range(1, 12)) send(8'($urandom_range(0, 255)));
        else send_frame(len, r != 1);  // r == 1 leaves the frame open
      end
      phase_no++;
    end

    settle();
    repeat (8) @(posedge clk);
    $display("covered %0d stream words over %0d length settings, incl. a long sink hold-off",
             stream_words, phase_no + 1);
    $display("checked %0d frame words, %0d frame ends, %0d with a length verdict",
             frame_words, frame_ends, off_length);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
